// File: sv/first_sort_group_finder_macros.svh
// ---------------------------------------------------------------------------
// First sort group finder assertion macros
// Shared concurrent assertion forms; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef FIRST_SORT_GROUP_FINDER_MACROS_SVH
`define FIRST_SORT_GROUP_FINDER_MACROS_SVH

`ifndef SYNTHESIS

`define FSGF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FSGF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FSGF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`define FSGF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: sv/fsgf_pkg.sv
// ---------------------------------------------------------------------------
// First sort group finder package
// Per-name state type, Latin fold tables and the fold function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsgf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned EXTA_N  = 20;

    localparam logic [BYTE_W-1:0] NON_ASCII_RESET = 8'd127;

    typedef struct packed {
        logic              decided;
        logic [BYTE_W-1:0] group_value;
        logic              ended;
        logic [1:0]        bytes_expected;
        logic [CP_W-1:0]   codepoint_accum;
    } name_state_t;

    localparam name_state_t STATE_CLEAR = '0;

    localparam logic [BYTE_W-1:0] LATIN1_BASE [64] = '{
        "a","a","a","a","a","a",8'h00,"c","e","e","e","e","i","i","i","i",
        "d","n","o","o","o","o","o",8'h00,"o","u","u","u","u","y",8'h00,8'h00,
        "a","a","a","a","a","a",8'h00,"c","e","e","e","e","i","i","i","i",
        "d","n","o","o","o","o","o",8'h00,"o","u","u","u","u","y",8'h00,"y"
    };

    localparam logic [8:0] EXTA_TOP [EXTA_N] = '{
        9'h105, 9'h10D, 9'h111, 9'h11B, 9'h123, 9'h127, 9'h133, 9'h135, 9'h137, 9'h142,
        9'h148, 9'h151, 9'h153, 9'h159, 9'h161, 9'h167, 9'h173, 9'h175, 9'h178, 9'h17F
    };

    localparam logic [BYTE_W-1:0] EXTA_BASE [EXTA_N] = '{
        "a","c","d","e","g","h","i","j","k","l",
        "n","o","o","r","s","t","u","w","y","z"
    };

    // Base letter of a Latin-1 / Latin Extended-A code point, zero if none.
    function automatic logic [BYTE_W-1:0] latin_base(input logic [CP_W-1:0] cp);
        logic [BYTE_W-1:0] res;
        res = '0;
        if (cp >= 21'h0000C0 && cp <= 21'h0000FF)
        begin
            res = LATIN1_BASE[cp[5:0]];
        end
        else if (cp >= 21'h000100 && cp <= 21'h00017F)
        begin
            for (int i = EXTA_N - 1; i >= 0; i--)
            begin
                if (cp[8:0] <= EXTA_TOP[i])
                begin
                    res = EXTA_BASE[i];
                end
            end
        end
        return res;
    endfunction

endpackage

// File: sv/fsgf_step.sv
// ---------------------------------------------------------------------------
// First sort group finder byte step
// Applies one name byte to the per-name state: ASCII classify, UTF-8 decode
// and Latin fold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsgf_step (
    input  fsgf_pkg::name_state_t cur_state,
    input  logic [7:0]            name_byte,
    input  logic [7:0]            fallback_group,
    output fsgf_pkg::name_state_t next_state
);

    logic [20:0] acc;
    logic [7:0]  base;
    logic        reexam;

    assign acc  = {cur_state.codepoint_accum[14:0], name_byte[5:0]};
    assign base = fsgf_pkg::latin_base(acc);

    always_comb
    begin
        next_state = cur_state;
        reexam     = 1'b1;
        if (!cur_state.decided && !cur_state.ended)
        begin
            if (cur_state.bytes_expected != 2'd0)
            begin
                if (name_byte[7:6] == 2'b10)
                begin
                    reexam                     = 1'b0;
                    next_state.codepoint_accum = acc;
                    next_state.bytes_expected  = cur_state.bytes_expected - 2'd1;
                    if (cur_state.bytes_expected == 2'd1 && acc != '0)
                    begin
                        next_state.decided     = 1'b1;
                        next_state.group_value = (base != '0) ? base : fallback_group;
                    end
                end
                else
                begin
                    next_state.bytes_expected  = 2'd0;
                    next_state.codepoint_accum = '0;
                end
            end

            if (reexam)
            begin
                if (name_byte == 8'h00)
                begin
                    next_state.ended = 1'b1;
                end
                else if (!name_byte[7])
                begin
                    if (name_byte inside {["0":"9"]})
                    begin
                        next_state.decided     = 1'b1;
                        next_state.group_value = "0";
                    end
                    else if (name_byte inside {["A":"Z"]})
                    begin
                        next_state.decided     = 1'b1;
                        next_state.group_value = name_byte + 8'd32;
                    end
                    else if (name_byte inside {["a":"z"]})
                    begin
                        next_state.decided     = 1'b1;
                        next_state.group_value = name_byte;
                    end
                end
                else if (name_byte[7:5] == 3'b110)
                begin
                    next_state.bytes_expected  = 2'd1;
                    next_state.codepoint_accum = {16'd0, name_byte[4:0]};
                end
                else if (name_byte[7:4] == 4'b1110)
                begin
                    next_state.bytes_expected  = 2'd2;
                    next_state.codepoint_accum = {17'd0, name_byte[3:0]};
                end
                else if (name_byte[7:3] == 5'b11110)
                begin
                    next_state.bytes_expected  = 2'd3;
                    next_state.codepoint_accum = {18'd0, name_byte[2:0]};
                end
            end
        end
    end

endmodule

// File: sv/first_sort_group_finder.sv
// ---------------------------------------------------------------------------
// First sort group finder
// Finds the sort group character of a UTF-8 name, one byte per beat.
// ---------------------------------------------------------------------------
// Input channel name_*: one name byte per beat, last_byte flags the final
// byte of a name. Output channel group_*: one group_char beat per name,
// issued for the beat flagged last. Config channel cfg_*: writes the
// fallback_group register; always ready, write only while idle.
// Path: a byte is captured in an input register, then decoded from there
// into the per-name state register and, on the last byte, into the result
// register, which drives group_valid.
// Throughput: one byte per cycle unless a last byte waits on a full result
// register, with combinational decode and fold from the input register.
// Reset: per-name state cleared, no result pending, fallback_group = 127.
// Receiver stall: the result register holds; further bytes of the next name
// keep flowing until its last byte reaches the input register, which then
// holds it, and name_ready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_sort_group_finder_macros.svh"

module first_sort_group_finder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       name_valid,
    output logic       name_ready,
    input  logic [7:0] name_byte,
    input  logic       last_byte,
    output logic       group_valid,
    input  logic       group_ready,
    output logic [7:0] group_char,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] fallback_group
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic [7:0]            group_reg;
    logic [7:0]            group_next;
    logic                  group_valid_reg;
    logic [7:0]            non_ascii_reg;
    fsgf_pkg::name_state_t state_reg;
    fsgf_pkg::name_state_t state_next;
    fsgf_pkg::name_state_t step_state;
    logic                  adv;

    assign adv        = in_valid_reg && (!in_last_reg || !group_valid_reg || group_ready);
    assign name_ready = !in_valid_reg || adv;
    assign cfg_ready  = 1'b1;

    fsgf_step u_step (
        .cur_state      (state_reg),
        .name_byte      (in_byte_reg),
        .fallback_group (non_ascii_reg),
        .next_state     (step_state)
    );

    always_comb
    begin
        state_next = state_reg;
        group_next = step_state.decided ? step_state.group_value : 8'd0;
        if (adv)
        begin
            state_next = in_last_reg ? fsgf_pkg::STATE_CLEAR : step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (name_ready)
        begin
            in_valid_reg <= name_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (name_ready && name_valid)
        begin
            in_byte_reg <= name_byte;
            in_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fsgf_pkg::STATE_CLEAR;
            group_valid_reg <= 1'b0;
            non_ascii_reg   <= fsgf_pkg::NON_ASCII_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (adv && in_last_reg)
            begin
                group_valid_reg <= 1'b1;
            end
            else if (group_ready)
            begin
                group_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                non_ascii_reg <= fallback_group;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_last_reg)
        begin
            group_reg <= group_next;
        end
    end

    assign group_valid = group_valid_reg;
    assign group_char  = group_reg;

    // last byte through decode always yields a pending result
    `FSGF_ASSERT_NEXT(a_last_gives_result, clk, rst_n, adv && in_last_reg, group_valid_reg, "result missing after last byte")
    // a decided name has no open sequence
    `FSGF_ASSERT_SAME(a_decided_closed, clk, rst_n, state_reg.decided, state_reg.bytes_expected == 2'd0, "open sequence after decision")
    // an ended name is never decided
    `FSGF_ASSERT_SAME(a_ended_undecided, clk, rst_n, state_reg.ended, !state_reg.decided, "ended name decided")
    // last byte never advances into a result register that is still blocked
    `FSGF_ASSERT_SAME(a_no_overwrite, clk, rst_n, adv && in_last_reg && group_valid_reg, group_ready, "result overwritten")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// First sort group finder testbench
// Streams UTF-8 names into the block one byte per beat and checks the group
// character returned for each name against a behavioral decoder and Latin
// fold in the bench. Short directed names come first, then random names:
// mostly well-formed letters, digits and multi-byte sequences with random
// code points, plus noise, broken and cut-off sequences and zero bytes.
// The non-ASCII group register is rewritten between drained phases. Both
// channels idle in random bursts except in the final phase.
// ---------------------------------------------------------------------------

module tb;

    localparam int unsigned BYTE_W = fsgf_pkg::BYTE_W;
    localparam int unsigned CP_W   = fsgf_pkg::CP_W;
    localparam logic [BYTE_W-1:0] NON_ASCII_RESET = fsgf_pkg::NON_ASCII_RESET;

    localparam int unsigned WATCHDOG_CYCLES = 2000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam logic [BYTE_W-1:0] GROUP_NONE  = 8'h00;
    localparam logic [BYTE_W-1:0] GROUP_DIGIT = "0";

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } name_beat_t;

    // {byte, last} pairs
    localparam logic [8:0] OPENING_NAMES [27] = '{
        {8'h5A, 1'b1},
        {8'h21, 1'b0}, {8'h39, 1'b1},
        {8'h80, 1'b0}, {8'hF8, 1'b0}, {8'h4D, 1'b1},
        {8'hC3, 1'b0}, {8'h89, 1'b1},
        {8'hC0, 1'b0}, {8'h81, 1'b1},
        {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'hAC, 1'b1},
        {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'h98, 1'b0}, {8'h80, 1'b1},
        {8'hC3, 1'b0}, {8'h62, 1'b1},
        {8'hE1, 1'b0}, {8'h80, 1'b1},
        {8'hC0, 1'b0}, {8'h80, 1'b0}, {8'h6B, 1'b1},
        {8'h00, 1'b0}, {8'h78, 1'b1},
        {8'hFF, 1'b1}
    };

    logic              clk             = 1'b0;
    logic              rst_n           = 1'b0;
    logic              name_valid      = 1'b0;
    logic              name_ready;
    logic [BYTE_W-1:0] name_byte       = '0;
    logic              last_byte       = 1'b0;
    logic              group_valid;
    logic              group_ready     = 1'b0;
    logic [BYTE_W-1:0] group_char;
    logic              cfg_valid       = 1'b0;
    logic              cfg_ready;
    logic [BYTE_W-1:0] fallback_group  = NON_ASCII_RESET;

    name_beat_t        beat_q[$];
    logic [BYTE_W-1:0] word_buf[$];
    logic [BYTE_W-1:0] group_q[$];
    name_beat_t        next_beat;
    logic [BYTE_W-1:0] want_group;

    // bench copy of the register and the per-name decode state
    logic [BYTE_W-1:0] cur_non_ascii = NON_ASCII_RESET;
    logic              nm_decided    = 1'b0;
    logic [BYTE_W-1:0] nm_group      = '0;
    logic              nm_ended      = 1'b0;
    logic [1:0]        cont_left     = '0;
    logic [CP_W-1:0]   cp_acc        = '0;

    bit          idle_on     = 1'b1;
    int unsigned src_gap     = 0;
    int unsigned sink_gap    = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_queued    = 0;
    int unsigned n_sent      = 0;
    int unsigned n_names     = 0;
    int unsigned n_cfg       = 0;
    int unsigned n_err       = 0;

    first_sort_group_finder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .name_valid     (name_valid),
        .name_ready     (name_ready),
        .name_byte      (name_byte),
        .last_byte      (last_byte),
        .group_valid    (group_valid),
        .group_ready    (group_ready),
        .group_char     (group_char),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .fallback_group (fallback_group)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [BYTE_W-1:0] fold_latin(input logic [CP_W-1:0] cp);
        logic [BYTE_W-1:0] letter;
        letter = GROUP_NONE;
        if (cp >= 21'h0C0 && cp <= 21'h0FF)
        begin
            // upper and lower halves of Latin-1 match except at the last slot
            case (cp[4:0])
                5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: letter = "a";
                5'd7:                               letter = "c";
                5'd8, 5'd9, 5'd10, 5'd11:           letter = "e";
                5'd12, 5'd13, 5'd14, 5'd15:         letter = "i";
                5'd16:                              letter = "d";
                5'd17:                              letter = "n";
                5'd18, 5'd19, 5'd20, 5'd21, 5'd22:  letter = "o";
                5'd24:                              letter = "o";
                5'd25, 5'd26, 5'd27, 5'd28:         letter = "u";
                5'd29:                              letter = "y";
                5'd31:                              letter = cp[5] ? "y" : GROUP_NONE;
                default:                            letter = GROUP_NONE;
            endcase
        end
        else if (cp >= 21'h100 && cp <= 21'h17F)
        begin
            if      (cp <= 21'h105) letter = "a";
            else if (cp <= 21'h10D) letter = "c";
            else if (cp <= 21'h111) letter = "d";
            else if (cp <= 21'h11B) letter = "e";
            else if (cp <= 21'h123) letter = "g";
            else if (cp <= 21'h127) letter = "h";
            else if (cp <= 21'h133) letter = "i";
            else if (cp <= 21'h135) letter = "j";
            else if (cp <= 21'h137) letter = "k";
            else if (cp <= 21'h142) letter = "l";
            else if (cp <= 21'h148) letter = "n";
            else if (cp <= 21'h153) letter = "o";
            else if (cp <= 21'h159) letter = "r";
            else if (cp <= 21'h161) letter = "s";
            else if (cp <= 21'h167) letter = "t";
            else if (cp <= 21'h173) letter = "u";
            else if (cp <= 21'h175) letter = "w";
            else if (cp <= 21'h178) letter = "y";
            else                    letter = "z";
        end
        return letter;
    endfunction

    function automatic void settle(input logic [BYTE_W-1:0] g);
        nm_decided = 1'b1;
        nm_group   = g;
    endfunction

    function automatic void predict_group(input logic [BYTE_W-1:0] b, input logic fin);
        logic [BYTE_W-1:0] letter;
        if (!nm_decided && !nm_ended)
        begin
            if (cont_left != 0 && b[7:6] == 2'b10)
            begin
                cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 0 && cp_acc != 0)
                begin
                    letter = fold_latin(cp_acc);
                    settle(letter != GROUP_NONE ? letter : cur_non_ascii);
                end
            end
            else
            begin
                // an open sequence broken here is dropped, the byte looked at anew
                cont_left = '0;
                cp_acc    = '0;
                if (b == 8'h00)
                    nm_ended = 1'b1;
                else if (b < 8'h80)
                begin
                    if (b >= "0" && b <= "9")
                        settle(GROUP_DIGIT);
                    else if (b >= "A" && b <= "Z")
                        settle(b + 8'd32);
                    else if (b >= "a" && b <= "z")
                        settle(b);
                end
                else if (b[7:5] == 3'b110)
                begin
                    cont_left = 2'd1;
                    cp_acc    = CP_W'(b[4:0]);
                end
                else if (b[7:4] == 4'b1110)
                begin
                    cont_left = 2'd2;
                    cp_acc    = CP_W'(b[3:0]);
                end
                else if (b[7:3] == 5'b11110)
                begin
                    cont_left = 2'd3;
                    cp_acc    = CP_W'(b[2:0]);
                end
            end
        end
        if (fin)
        begin
            group_q.push_back(nm_decided ? nm_group : GROUP_NONE);
            nm_decided = 1'b0;
            nm_group   = '0;
            nm_ended   = 1'b0;
            cont_left  = '0;
            cp_acc     = '0;
        end
    endfunction

    function automatic void put_cp(input logic [CP_W-1:0] cp, input int unsigned n);
        case (n)
            2:
            begin
                word_buf.push_back({3'b110, cp[10:6]});
                word_buf.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                word_buf.push_back({4'b1110, cp[15:12]});
                word_buf.push_back({2'b10, cp[11:6]});
                word_buf.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                word_buf.push_back({5'b11110, cp[20:18]});
                word_buf.push_back({2'b10, cp[17:12]});
                word_buf.push_back({2'b10, cp[11:6]});
                word_buf.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void end_name();
        name_beat_t nb;
        for (int i = 0; i < word_buf.size(); i++)
        begin
            nb.data = word_buf[i];
            nb.last = (i == word_buf.size() - 1);
            beat_q.push_back(nb);
        end
        n_queued += word_buf.size();
        word_buf.delete();
    endfunction

    function automatic void rand_name();
        int unsigned lead_n;
        int unsigned tail_n;
        int unsigned need;
        logic [BYTE_W-1:0] b;
        lead_n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        tail_n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < lead_n; i++)
        begin
            case ($urandom_range(0, 2))
                0:       word_buf.push_back(8'($urandom_range(8'h01, 8'h2F)));
                1:       word_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
                default: word_buf.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            endcase
        end
        case ($urandom_range(0, 11))
            0:      word_buf.push_back(8'($urandom_range(8'h30, 8'h39)));
            1:      word_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
            2:      word_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
            3, 4:   put_cp(CP_W'($urandom_range(21'h0C0, 21'h17F)), 2);
            5:      put_cp(CP_W'($urandom_range(0, 21'h7FF)), 2);
            6:      put_cp(CP_W'($urandom_range(0, 21'hFFFF)), 3);
            7:      put_cp(CP_W'($urandom_range(0, 21'h1FFFFF)), 4);
            8:
            begin
                // sequence broken by a non-continuation, or cut off by the name end
                need = $urandom_range(1, 3);
                b = 8'($urandom_range(0, 255));
                case (need)
                    1:       word_buf.push_back({3'b110, b[4:0]});
                    2:       word_buf.push_back({4'b1110, b[3:0]});
                    default: word_buf.push_back({5'b11110, b[2:0]});
                endcase
                for (int i = int'($urandom_range(0, need - 1)); i > 0; i--)
                    word_buf.push_back({2'b10, 6'($urandom_range(0, 63))});
                if ($urandom_range(0, 1) == 0)
                begin
                    b = 8'($urandom_range(0, 191));
                    word_buf.push_back(b >= 8'h80 ? b + 8'h40 : b);
                end
                else
                    tail_n = 0;
            end
            9:
            begin
                for (int i = int'($urandom_range(1, 6)); i > 0; i--)
                    word_buf.push_back(8'($urandom_range(0, 255)));
            end
            10:     put_cp('0, $urandom_range(2, 4));
            default:
            begin
                word_buf.push_back(8'h00);
                tail_n = $urandom_range(1, 3);
            end
        endcase
        for (int i = 0; i < tail_n; i++)
            word_buf.push_back(8'($urandom_range(0, 255)));
        end_name();
    endfunction

    task automatic queue_names(input int unsigned n);
        int unsigned target;
        target = n_queued + n;
        while (n_queued < target)
            rand_name();
    endtask

    task automatic drain();
        while (n_sent != n_queued || group_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_group_cfg(input logic [BYTE_W-1:0] value);
        @(posedge clk);
        cfg_valid      <= 1'b1;
        fallback_group <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid     <= 1'b0;
        cur_non_ascii  = value;
        n_cfg++;
    endtask

    // byte driver and predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_valid <= 1'b0;
        end
        else
        begin
            if (name_valid && name_ready)
            begin
                predict_group(name_byte, last_byte);
                n_sent++;
            end
            if (!name_valid || name_ready)
            begin
                if (src_gap != 0)
                begin
                    src_gap--;
                    name_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 9) == 0)
                begin
                    src_gap = $urandom_range(0, 17);
                    name_valid <= 1'b0;
                end
                else if (beat_q.size() != 0)
                begin
                    next_beat = beat_q.pop_front();
                    name_valid <= 1'b1;
                    name_byte  <= next_beat.data;
                    last_byte  <= next_beat.last;
                end
                else
                begin
                    name_valid <= 1'b0;
                end
            end
        end
    end

    // group monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_ready <= 1'b0;
        end
        else
        begin
            if (group_valid && group_ready)
            begin
                if (group_q.size() == 0)
                begin
                    $display("%0t: unexpected group beat, expected none, got %02h",
                             $time, group_char);
                    n_err++;
                end
                else
                begin
                    want_group = group_q.pop_front();
                    n_names++;
                    if (group_char !== want_group)
                    begin
                        $display("%0t: group_char mismatch, expected %02h, got %02h",
                                 $time, want_group, group_char);
                        n_err++;
                    end
                end
            end
            if (sink_gap != 0)
            begin
                sink_gap--;
                group_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(0, 17);
                group_ready <= 1'b0;
            end
            else
            begin
                group_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((name_valid && name_ready) || (group_valid && group_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_CYCLES)
            @(posedge clk);
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        name_beat_t nb;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 27; i++)
        begin
            nb = OPENING_NAMES[i];
            beat_q.push_back(nb);
        end
        n_queued += 27;
        queue_names(300);
        drain();

        // sender held off until the receiver has caught up
        queue_names(200);
        drain();

        write_group_cfg(8'd1);
        queue_names(250);
        drain();

        write_group_cfg(8'd255);
        queue_names(250);
        drain();

        // register at zero: such names read back like names with no group
        write_group_cfg(8'd0);
        word_buf.push_back(8'hE2);
        word_buf.push_back(8'h82);
        word_buf.push_back(8'hAC);
        end_name();
        queue_names(150);
        drain();

        write_group_cfg(8'($urandom_range(1, 255)));
        queue_names(300);
        drain();

        write_group_cfg(8'($urandom_range(1, 255)));
        idle_on = 1'b0;
        queue_names(200);
        drain();

        $display("Checked %0d names (%0d bytes) across %0d register settings.",
                 n_names, n_sent, n_cfg + 1);
        $display("Covered ASCII, Latin folds, multi-byte, broken, cut-off and zero input; %0d errors.",
                 n_err);
        if (n_err == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
